// ===== rtl/core/ihm_pkg.sv =====
// ----------------------------------------------------------------------------
// ihm_pkg
// Shared types and constants of the insertion-ordered hash map unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ihm_pkg;

   localparam int CAPACITY = 64;
   localparam int POS_W    = $clog2(CAPACITY);
   localparam int CNT_W    = POS_W + 1;
   localparam int KEY_W    = 64;
   localparam int HASH_W   = 32;
   localparam int VAL_W    = 64;
   localparam int SPOS_W   = 7;
   localparam int REQ_W    = 168;
   localparam int RSP_W    = 136;

   typedef enum logic [1:0] {
      KIND_GET  = 2'd0,
      KIND_SET  = 2'd1,
      KIND_DEL  = 2'd2,
      KIND_NEXT = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [KEY_W-1:0]     key;
      logic [POS_W-1:0]     bucket;
      logic [VAL_W-1:0]     value;
      logic [SPOS_W-1:0]    start;
   } item_type;

   typedef struct packed {
      logic valid;
   } queue_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HEAD,
      ST_CHAIN,
      ST_IT_SCAN,
      ST_IT_READ,
      ST_CP_SCAN,
      ST_CP_HEAD,
      ST_CP_WRITE,
      ST_AP_WAIT,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/insertion_ordered_hash_map_unit.sv =====
// ----------------------------------------------------------------------------
// insertion_ordered_hash_map_unit
// Hash map of up to 64 entries kept in insertion order, one result per item.
// ----------------------------------------------------------------------------
// Channel | Direction | Contents
// req_    | in        | tuser kind; tdata key, key_hash, new_value, start_position
// rsp_    | out       | tuser found, status; tdata out_key, out_value, next_position
//
// A get, set or delete reads the chain head and then walks the chain one link
// at a time, and a set that misses then appends; iterate next scans position by
// position from the start. A set into a full store with dead entries first
// compacts it, moving each live entry down and relinking it. Reset clears the
// chains and counts. A two-word queue lets requests arrive while the back
// end works, and the result register frees the back end while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module insertion_ordered_hash_map_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // key[63:0], key_hash[95:64], new_value[159:96], start_position[166:160]
   input  wire logic [ihm_pkg::REQ_W-1:0]  req_tdata,
   // kind[1:0]
   input  wire logic [1:0]                 req_tuser,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // out_key[63:0], out_value[127:64], next_position[134:128]
   output logic [ihm_pkg::RSP_W-1:0]       rsp_tdata,
   // found[0], status[1]
   output logic [1:0]                      rsp_tuser
);

   ihm_pkg::item_type      q_item;
   ihm_pkg::queue_ctl_type q_ctl;
   logic                   q_pop;
   logic                   q_valid;

   assign q_ctl.valid = q_valid;

   // Accept and queue
   ihm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .q_valid    (q_valid)
   );

   // Execute and respond
   ihm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_item     (q_item),
      .q_ctl_i    (q_ctl),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== rtl/core/ihm_front.sv =====
// ----------------------------------------------------------------------------
// ihm_front
// Accepts request words, extracts the bucket and queues items for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module ihm_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [ihm_pkg::REQ_W-1:0]  req_tdata,
   input  wire logic [1:0]                 req_tuser,
   output ihm_pkg::item_type               q_item,
   input  wire logic                       q_pop,
   output logic                            q_valid
);

   ihm_pkg::item_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   ihm_pkg::item_type new_item;
   logic              push;

   // Classify the incoming word
   always_comb begin
      new_item.kind   = ihm_pkg::kind_type'(req_tuser);
      new_item.key    = req_tdata[63:0];
      new_item.bucket = req_tdata[64 +: ihm_pkg::POS_W];
      new_item.value  = req_tdata[159:96];
      new_item.start  = req_tdata[166:160];
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (cnt_ff != 2'd0);
   assign q_item     = entry_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ (q_pop && q_valid);
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, q_pop && q_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Hold queued items
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ihm_back.sv =====
// ----------------------------------------------------------------------------
// ihm_back
// Carries out queued items: chain walk, append, compaction and iteration.
// ----------------------------------------------------------------------------
`default_nettype none

module ihm_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ihm_pkg::item_type          q_item,
   input  wire ihm_pkg::queue_ctl_type     q_ctl_i,
   output logic                            q_pop,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [ihm_pkg::RSP_W-1:0]       rsp_tdata,
   output logic [1:0]                      rsp_tuser
);

   localparam int PW = ihm_pkg::POS_W;
   localparam int CW = ihm_pkg::CNT_W;
   localparam logic [CW-1:0] CAP_C = CW'(ihm_pkg::CAPACITY);

   // Entry stores
   logic [ihm_pkg::KEY_W-1:0] key_mem  [ihm_pkg::CAPACITY];
   logic [ihm_pkg::VAL_W-1:0] val_mem  [ihm_pkg::CAPACITY];
   logic [PW-1:0]             bkt_mem  [ihm_pkg::CAPACITY];
   logic [CW-1:0]             nxt_mem  [ihm_pkg::CAPACITY];
   logic [CW-1:0]             head_mem [ihm_pkg::CAPACITY];

   logic [ihm_pkg::KEY_W-1:0] key_rd_ff;
   logic [ihm_pkg::VAL_W-1:0] val_rd_ff;
   logic [PW-1:0]             bkt_rd_ff;
   logic [CW-1:0]             nxt_rd_ff;
   logic [CW-1:0]             head_rd_ff;
   logic                      head_ok_ff;

   logic                       rd_en;
   logic [PW-1:0]              rd_addr;
   logic                       hd_rd_en;
   logic [PW-1:0]              hd_raddr;
   logic                       key_we, val_we, bkt_we, nxt_we, hd_we;
   logic [PW-1:0]              wr_addr;
   logic [ihm_pkg::KEY_W-1:0]  key_wd;
   logic [ihm_pkg::VAL_W-1:0]  val_wd;
   logic [PW-1:0]              bkt_wd;
   logic [CW-1:0]              nxt_wd;
   logic [PW-1:0]              hd_waddr;
   logic [CW-1:0]              hd_wd;

   // Control and working state
   ihm_pkg::state_type         state_ff, state_in;
   ihm_pkg::item_type          item_ff, item_in;
   logic [ihm_pkg::CAPACITY-1:0] live_ff, live_in;
   logic [ihm_pkg::CAPACITY-1:0] hv_ff, hv_in;
   logic [CW-1:0]              used_ff, used_in;
   logic [CW-1:0]              lcnt_ff, lcnt_in;
   logic [CW-1:0]              at_ff, at_in;
   logic [ihm_pkg::SPOS_W-1:0] i_ff, i_in;
   logic [CW-1:0]              dst_ff, dst_in;
   logic                       found_ff, found_in;
   logic                       status_ff, status_in;
   logic [ihm_pkg::KEY_W-1:0]  okey_ff, okey_in;
   logic [ihm_pkg::VAL_W-1:0]  oval_ff, oval_in;
   logic [ihm_pkg::SPOS_W-1:0] npos_ff, npos_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_load;
   logic [1:0]                 rsp_user_ff;
   logic [ihm_pkg::RSP_W-1:0]  rsp_data_ff;

   logic [CW-1:0]              head_cur;
   logic                       hit, miss, full_all, need_cp;

   assign head_cur = head_ok_ff ? head_rd_ff : CAP_C;
   assign hit      = (state_ff == ihm_pkg::ST_CHAIN) && live_ff[at_ff[PW-1:0]] &&
                     (key_rd_ff == item_ff.key);
   assign miss     = ((state_ff == ihm_pkg::ST_HEAD) && head_cur[PW]) ||
                     ((state_ff == ihm_pkg::ST_CHAIN) && !hit && nxt_rd_ff[PW]);
   assign full_all = (lcnt_ff == CAP_C);
   assign need_cp  = (used_ff == CAP_C);
   assign rsp_load = (state_ff == ihm_pkg::ST_RESP) && (!rsp_valid_ff || rsp_tready);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ihm_pkg::ST_IDLE: begin
            if (q_ctl_i.valid) begin
               state_in = (q_item.kind == ihm_pkg::KIND_NEXT) ? ihm_pkg::ST_IT_SCAN
                                                              : ihm_pkg::ST_HEAD;
            end
         end
         ihm_pkg::ST_HEAD, ihm_pkg::ST_CHAIN: begin
            if (hit) begin
               state_in = ihm_pkg::ST_RESP;
            end else if (miss) begin
               if (item_ff.kind != ihm_pkg::KIND_SET || (need_cp && full_all)) begin
                  state_in = ihm_pkg::ST_RESP;
               end else if (need_cp) begin
                  state_in = ihm_pkg::ST_CP_SCAN;
               end else begin
                  state_in = ihm_pkg::ST_AP_WAIT;
               end
            end else begin
               state_in = ihm_pkg::ST_CHAIN;
            end
         end
         ihm_pkg::ST_IT_SCAN: begin
            if (CW'(i_ff) >= used_ff) begin
               state_in = ihm_pkg::ST_RESP;
            end else if (live_ff[i_ff[PW-1:0]]) begin
               state_in = ihm_pkg::ST_IT_READ;
            end
         end
         ihm_pkg::ST_IT_READ:  state_in = ihm_pkg::ST_RESP;
         ihm_pkg::ST_CP_SCAN: begin
            if (CW'(i_ff) == used_ff) begin
               state_in = ihm_pkg::ST_AP_WAIT;
            end else if (live_ff[i_ff[PW-1:0]]) begin
               state_in = ihm_pkg::ST_CP_HEAD;
            end
         end
         ihm_pkg::ST_CP_HEAD:  state_in = ihm_pkg::ST_CP_WRITE;
         ihm_pkg::ST_CP_WRITE: state_in = ihm_pkg::ST_CP_SCAN;
         ihm_pkg::ST_AP_WAIT:  state_in = ihm_pkg::ST_RESP;
         ihm_pkg::ST_RESP: begin
            if (rsp_load) begin
               state_in = ihm_pkg::ST_IDLE;
            end
         end
         default: state_in = ihm_pkg::ST_IDLE;
      endcase
   end

   // Datapath and memory controls
   always_comb begin
      q_pop     = 1'b0;
      item_in   = item_ff;
      live_in   = live_ff;
      hv_in     = hv_ff;
      used_in   = used_ff;
      lcnt_in   = lcnt_ff;
      at_in     = at_ff;
      i_in      = i_ff;
      dst_in    = dst_ff;
      found_in  = found_ff;
      status_in = status_ff;
      okey_in   = okey_ff;
      oval_in   = oval_ff;
      npos_in   = npos_ff;
      rd_en     = 1'b0;
      rd_addr   = at_ff[PW-1:0];
      hd_rd_en  = 1'b0;
      hd_raddr  = item_ff.bucket;
      key_we    = 1'b0;
      val_we    = 1'b0;
      bkt_we    = 1'b0;
      nxt_we    = 1'b0;
      hd_we     = 1'b0;
      wr_addr   = at_ff[PW-1:0];
      key_wd    = item_ff.key;
      val_wd    = item_ff.value;
      bkt_wd    = item_ff.bucket;
      nxt_wd    = head_cur;
      hd_waddr  = item_ff.bucket;
      hd_wd     = used_ff;
      unique case (state_ff)
         ihm_pkg::ST_IDLE: begin
            if (q_ctl_i.valid) begin
               q_pop     = 1'b1;
               item_in   = q_item;
               i_in      = q_item.start;
               found_in  = 1'b0;
               status_in = 1'b0;
               okey_in   = '0;
               oval_in   = '0;
               npos_in   = '0;
               hd_rd_en  = 1'b1;
               hd_raddr  = q_item.bucket;
            end
         end
         ihm_pkg::ST_HEAD, ihm_pkg::ST_CHAIN: begin
            if (hit) begin
               // Act on the live entry found
               unique case (item_ff.kind)
                  ihm_pkg::KIND_GET: begin
                     found_in = 1'b1;
                     oval_in  = val_rd_ff;
                  end
                  ihm_pkg::KIND_SET: begin
                     val_we = 1'b1;
                  end
                  ihm_pkg::KIND_DEL: begin
                     found_in                 = 1'b1;
                     live_in[at_ff[PW-1:0]]   = 1'b0;
                     lcnt_in                  = lcnt_ff - CW'(1);
                  end
                  default: ;
               endcase
            end else if (miss) begin
               if (item_ff.kind == ihm_pkg::KIND_SET) begin
                  if (need_cp && full_all) begin
                     status_in = 1'b1;
                  end else if (need_cp) begin
                     // Start compaction: drop every chain
                     hv_in  = '0;
                     i_in   = '0;
                     dst_in = '0;
                  end else begin
                     hd_rd_en = 1'b1;
                  end
               end
            end else begin
               // Follow the chain one link
               at_in   = (state_ff == ihm_pkg::ST_HEAD) ? head_cur : nxt_rd_ff;
               rd_en   = 1'b1;
               rd_addr = at_in[PW-1:0];
            end
         end
         ihm_pkg::ST_IT_SCAN: begin
            if (CW'(i_ff) >= used_ff) begin
               found_in = 1'b0;
            end else if (live_ff[i_ff[PW-1:0]]) begin
               rd_en   = 1'b1;
               rd_addr = i_ff[PW-1:0];
            end else begin
               i_in = i_ff + ihm_pkg::SPOS_W'(1);
            end
         end
         ihm_pkg::ST_IT_READ: begin
            found_in = 1'b1;
            okey_in  = key_rd_ff;
            oval_in  = val_rd_ff;
            npos_in  = i_ff + ihm_pkg::SPOS_W'(1);
         end
         ihm_pkg::ST_CP_SCAN: begin
            if (CW'(i_ff) == used_ff) begin
               // Finish compaction and fetch the chain head for the append
               for (int k = 0; k < ihm_pkg::CAPACITY; k++) begin
                  live_in[k] = live_ff[k] && (CW'(k) < dst_ff);
               end
               used_in  = dst_ff;
               lcnt_in  = dst_ff;
               hd_rd_en = 1'b1;
            end else if (live_ff[i_ff[PW-1:0]]) begin
               rd_en   = 1'b1;
               rd_addr = i_ff[PW-1:0];
            end else begin
               i_in = i_ff + ihm_pkg::SPOS_W'(1);
            end
         end
         ihm_pkg::ST_CP_HEAD: begin
            hd_rd_en = 1'b1;
            hd_raddr = bkt_rd_ff;
         end
         ihm_pkg::ST_CP_WRITE: begin
            // Move the live entry down and relink it
            key_we   = 1'b1;
            val_we   = 1'b1;
            bkt_we   = 1'b1;
            nxt_we   = 1'b1;
            hd_we    = 1'b1;
            wr_addr  = dst_ff[PW-1:0];
            key_wd   = key_rd_ff;
            val_wd   = val_rd_ff;
            bkt_wd   = bkt_rd_ff;
            hd_waddr = bkt_rd_ff;
            hd_wd    = dst_ff;
            hv_in[bkt_rd_ff]        = 1'b1;
            live_in[dst_ff[PW-1:0]] = 1'b1;
            dst_in   = dst_ff + CW'(1);
            i_in     = i_ff + ihm_pkg::SPOS_W'(1);
         end
         ihm_pkg::ST_AP_WAIT: begin
            // Append the new entry at the head of its chain
            key_we   = 1'b1;
            val_we   = 1'b1;
            bkt_we   = 1'b1;
            nxt_we   = 1'b1;
            hd_we    = 1'b1;
            wr_addr  = used_ff[PW-1:0];
            hv_in[item_ff.bucket]    = 1'b1;
            live_in[used_ff[PW-1:0]] = 1'b1;
            used_in  = used_ff + CW'(1);
            lcnt_in  = lcnt_ff + CW'(1);
            found_in = 1'b1;
         end
         ihm_pkg::ST_RESP: ;
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ihm_pkg::ST_IDLE;
         live_ff      <= '0;
         hv_ff        <= '0;
         used_ff      <= '0;
         lcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         hv_ff        <= hv_in;
         used_ff      <= used_in;
         lcnt_ff      <= lcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      at_ff     <= at_in;
      i_ff      <= i_in;
      dst_ff    <= dst_in;
      found_ff  <= found_in;
      status_ff <= status_in;
      okey_ff   <= okey_in;
      oval_ff   <= oval_in;
      npos_ff   <= npos_in;
      if (rsp_load) begin
         rsp_user_ff <= {status_ff, found_ff};
         rsp_data_ff <= {1'b0, npos_ff, oval_ff, okey_ff};
      end
   end

   // Entry memories
   always_ff @(posedge clock) begin
      if (key_we) key_mem[wr_addr] <= key_wd;
      if (val_we) val_mem[wr_addr] <= val_wd;
      if (bkt_we) bkt_mem[wr_addr] <= bkt_wd;
      if (nxt_we) nxt_mem[wr_addr] <= nxt_wd;
      if (rd_en) begin
         key_rd_ff <= key_mem[rd_addr];
         val_rd_ff <= val_mem[rd_addr];
         bkt_rd_ff <= bkt_mem[rd_addr];
         nxt_rd_ff <= nxt_mem[rd_addr];
      end
   end

   // Chain head memory
   always_ff @(posedge clock) begin
      if (hd_we) head_mem[hd_waddr] <= hd_wd;
      if (hd_rd_en) begin
         head_rd_ff <= head_mem[hd_raddr];
         head_ok_ff <= hv_ff[hd_raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

// ===== tb/insertion_ordered_hash_map_checker.sv =====
// ----------------------------------------------------------------------------
// insertion_ordered_hash_map_checker
// Watches both channels of the hash map unit, keeps its own copy of the map,
// works out the result of every accepted request word and compares each
// accepted response word against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module insertion_ordered_hash_map_checker (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   input  wire logic                       req_tready,
   input  wire logic [ihm_pkg::REQ_W-1:0]  req_tdata,
   input  wire logic [1:0]                 req_tuser,
   input  wire logic                       rsp_tvalid,
   input  wire logic                       rsp_tready,
   input  wire logic [ihm_pkg::RSP_W-1:0]  rsp_tdata,
   input  wire logic [1:0]                 rsp_tuser,
   output int                              error_count,
   output int                              outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [6:0] NO_LINK = 7'(ihm_pkg::CAPACITY);

   typedef struct packed {
      logic                      found;
      logic                      status;
      logic [ihm_pkg::KEY_W-1:0] key;
      logic [ihm_pkg::VAL_W-1:0] value;
      logic [6:0]                npos;
   } map_result_type;

   // shadow copy of the map
   logic [ihm_pkg::KEY_W-1:0] shadow_key   [ihm_pkg::CAPACITY];
   logic [ihm_pkg::VAL_W-1:0] shadow_value [ihm_pkg::CAPACITY];
   logic [5:0]                shadow_bucket[ihm_pkg::CAPACITY];
   logic [6:0]                shadow_next  [ihm_pkg::CAPACITY];
   logic [6:0]                shadow_head  [ihm_pkg::CAPACITY];
   logic                      shadow_live  [ihm_pkg::CAPACITY];
   int                        live_total;
   int                        used_total;

   map_result_type expected_results[$];

   // walk a chain, skipping dead entries
   function automatic int locate_live(logic [ihm_pkg::KEY_W-1:0] key, logic [5:0] bucket);
      int at;
      int steps;
      at = shadow_head[bucket];
      steps = 0;
      while (at < ihm_pkg::CAPACITY && steps < ihm_pkg::CAPACITY) begin
         if (shadow_live[at] && shadow_key[at] == key) return at;
         at = shadow_next[at];
         steps++;
      end
      return ihm_pkg::CAPACITY;
   endfunction

   // squeeze dead entries out and rebuild every chain
   task automatic squeeze_store();
      int dst;
      dst = 0;
      for (int i = 0; i < ihm_pkg::CAPACITY; i++) shadow_head[i] = NO_LINK;
      for (int i = 0; i < used_total; i++) begin
         if (shadow_live[i]) begin
            shadow_key[dst]    = shadow_key[i];
            shadow_value[dst]  = shadow_value[i];
            shadow_bucket[dst] = shadow_bucket[i];
            shadow_live[dst]   = 1'b1;
            shadow_next[dst]   = shadow_head[shadow_bucket[dst]];
            shadow_head[shadow_bucket[dst]] = 7'(dst);
            dst++;
         end
      end
      for (int i = dst; i < ihm_pkg::CAPACITY; i++) shadow_live[i] = 1'b0;
      used_total = dst;
      live_total = dst;
   endtask

   task automatic apply_request(ihm_pkg::kind_type kind, logic [ihm_pkg::KEY_W-1:0] key,
                                logic [ihm_pkg::HASH_W-1:0] hash,
                                logic [ihm_pkg::VAL_W-1:0] value,
                                logic [6:0] start, output map_result_type res);
      logic [5:0] bucket;
      int at;
      bucket = hash[5:0];
      res = '0;
      case (kind)
         ihm_pkg::KIND_GET: begin
            at = locate_live(key, bucket);
            if (at < ihm_pkg::CAPACITY) begin
               res.found = 1'b1;
               res.value = shadow_value[at];
            end
         end
         ihm_pkg::KIND_SET: begin
            at = locate_live(key, bucket);
            if (at < ihm_pkg::CAPACITY) begin
               shadow_value[at] = value;
            end else begin
               if (used_total >= ihm_pkg::CAPACITY) begin
                  if (live_total >= ihm_pkg::CAPACITY) res.status = 1'b1;
                  else squeeze_store();
               end
               if (!res.status && used_total < ihm_pkg::CAPACITY) begin
                  at = used_total;
                  shadow_key[at]    = key;
                  shadow_value[at]  = value;
                  shadow_bucket[at] = bucket;
                  shadow_live[at]   = 1'b1;
                  shadow_next[at]   = shadow_head[bucket];
                  shadow_head[bucket] = 7'(at);
                  used_total++;
                  live_total++;
                  res.found = 1'b1;
               end
            end
         end
         ihm_pkg::KIND_DEL: begin
            at = locate_live(key, bucket);
            if (at < ihm_pkg::CAPACITY) begin
               shadow_live[at] = 1'b0;
               if (live_total > 0) live_total--;
               res.found = 1'b1;
            end
         end
         default: begin
            for (int i = start; i < used_total; i++) begin
               if (shadow_live[i]) begin
                  res.found = 1'b1;
                  res.key   = shadow_key[i];
                  res.value = shadow_value[i];
                  res.npos  = 7'(i + 1);
                  break;
               end
            end
         end
      endcase
   endtask

   // compare the response word first, then predict from the request word
   always @(posedge clock) begin
      map_result_type res;
      map_result_type got;
      if (reset) begin
         for (int i = 0; i < ihm_pkg::CAPACITY; i++) begin
            shadow_head[i] = NO_LINK;
            shadow_live[i] = 1'b0;
         end
         live_total = 0;
         used_total = 0;
         expected_results.delete();
         error_count = 0;
         outstanding = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.found  = rsp_tuser[0];
            got.status = rsp_tuser[1];
            got.key    = rsp_tdata[63:0];
            got.value  = rsp_tdata[127:64];
            got.npos   = rsp_tdata[134:128];
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response word %h", $realtime, got);
               error_count++;
            end else begin
               res = expected_results.pop_front();
               if (got.found !== res.found) begin
                  $display("%0t: found expected %b actual %b", $realtime, res.found, got.found);
                  error_count++;
               end
               if (got.status !== res.status) begin
                  $display("%0t: status expected %b actual %b", $realtime, res.status,
                           got.status);
                  error_count++;
               end
               if (got.key !== res.key) begin
                  $display("%0t: out_key expected %h actual %h", $realtime, res.key, got.key);
                  error_count++;
               end
               if (got.value !== res.value) begin
                  $display("%0t: out_value expected %h actual %h", $realtime, res.value,
                           got.value);
                  error_count++;
               end
               if (got.npos !== res.npos) begin
                  $display("%0t: next_position expected %0d actual %0d", $realtime, res.npos,
                           got.npos);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            apply_request(ihm_pkg::kind_type'(req_tuser), req_tdata[63:0], req_tdata[95:64],
                          req_tdata[159:96], req_tdata[166:160], res);
            expected_results.push_back(res);
         end
         outstanding = expected_results.size();
      end
   end

endmodule

`default_nettype wire

// ===== tb/insertion_ordered_hash_map_unit_test.sv =====
// ----------------------------------------------------------------------------
// insertion_ordered_hash_map_unit_test
// Drives gets, sets, deletes and iterate-next words into the hash map unit:
// a directed opening, a fill to a full store, then random traffic over a small
// key pool so that hits, chains, compaction and refusals all occur, under
// three idling patterns. The checker does the comparison; this gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module insertion_ordered_hash_map_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL = 72;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [ihm_pkg::REQ_W-1:0]     req_tdata = '0;
   logic [1:0]                    req_tuser = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [ihm_pkg::RSP_W-1:0]     rsp_tdata;
   logic [1:0]                    rsp_tuser;
   int                            error_count;
   int                            outstanding;

   int                            send_idle_pct = 0;
   int                            recv_idle_pct = 0;
   logic [ihm_pkg::KEY_W-1:0]     pool_key [POOL];
   logic [ihm_pkg::HASH_W-1:0]    pool_hash[POOL];

   always #2 clock = ~clock;

   insertion_ordered_hash_map_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   insertion_ordered_hash_map_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .error_count(error_count), .outstanding(outstanding)
   );

   // stall the response side at random
   always @(negedge clock) begin
      if (!reset) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // hold a request word until it is accepted
   task automatic send_word(ihm_pkg::kind_type kind, logic [ihm_pkg::KEY_W-1:0] key,
                            logic [ihm_pkg::HASH_W-1:0] hash,
                            logic [ihm_pkg::VAL_W-1:0] value, logic [6:0] start);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, start, value, hash, key};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drop_valid();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic random_word();
      int pick;
      int idx;
      ihm_pkg::kind_type kind;
      logic [ihm_pkg::KEY_W-1:0] key;
      logic [ihm_pkg::HASH_W-1:0] hash;
      pick = $urandom_range(99);
      idx = $urandom_range(POOL - 1);
      if (pick < 40) kind = ihm_pkg::KIND_SET;
      else if (pick < 65) kind = ihm_pkg::KIND_GET;
      else if (pick < 80) kind = ihm_pkg::KIND_DEL;
      else kind = ihm_pkg::KIND_NEXT;
      key = pool_key[idx];
      hash = pool_hash[idx];
      // noise: keys and hashes from nowhere
      if ($urandom_range(9) == 0) begin
         key = {$urandom, $urandom};
         hash = $urandom;
      end
      send_word(kind, key, hash, {$urandom, $urandom},
                ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(66)));
   endtask

   initial begin
      // key pool with crowded buckets so chains grow
      for (int i = 0; i < POOL; i++) begin
         pool_key[i]  = {$urandom, $urandom};
         pool_hash[i] = {$urandom} & 32'hFFFF_FFC0 | 32'($urandom_range(15));
      end
      pool_key[0] = '0;
      pool_hash[0] = '0;
      pool_key[1] = '1;
      pool_hash[1] = '1;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed opening
      send_word(ihm_pkg::KIND_NEXT, '0, '0, '0, 7'd0);
      send_word(ihm_pkg::KIND_GET, pool_key[0], pool_hash[0], '0, 7'd0);
      send_word(ihm_pkg::KIND_SET, pool_key[0], pool_hash[0], '1, 7'd0);
      send_word(ihm_pkg::KIND_SET, pool_key[1], pool_hash[1], '0, 7'd127);
      send_word(ihm_pkg::KIND_SET, pool_key[2], pool_hash[2], 64'h0123_4567_89AB_CDEF, 7'd0);
      send_word(ihm_pkg::KIND_GET, pool_key[0], pool_hash[0], '0, 7'd0);
      send_word(ihm_pkg::KIND_GET, pool_key[1], pool_hash[1], '0, 7'd0);
      send_word(ihm_pkg::KIND_SET, pool_key[0], pool_hash[0], 64'h5555_AAAA_5555_AAAA, 7'd0);
      send_word(ihm_pkg::KIND_GET, pool_key[0], pool_hash[0], '0, 7'd0);
      send_word(ihm_pkg::KIND_DEL, pool_key[0], pool_hash[0], '0, 7'd0);
      send_word(ihm_pkg::KIND_GET, pool_key[0], pool_hash[0], '0, 7'd0);
      send_word(ihm_pkg::KIND_DEL, pool_key[0], pool_hash[0], '0, 7'd0);
      send_word(ihm_pkg::KIND_DEL, pool_key[3], pool_hash[3], '0, 7'd0);
      send_word(ihm_pkg::KIND_NEXT, '0, '0, '0, 7'd0);
      send_word(ihm_pkg::KIND_NEXT, '0, '0, '0, 7'd1);
      send_word(ihm_pkg::KIND_NEXT, '0, '0, '0, 7'd2);
      send_word(ihm_pkg::KIND_NEXT, '0, '0, '0, 7'd3);
      send_word(ihm_pkg::KIND_NEXT, '0, '0, '0, 7'd64);
      send_word(ihm_pkg::KIND_NEXT, '0, '0, '0, 7'd127);
      send_word(ihm_pkg::KIND_SET, pool_key[0], pool_hash[0], 64'hFEED_0000_0000_BEEF, 7'd0);
      send_word(ihm_pkg::KIND_NEXT, '0, '0, '0, 7'd0);
      send_word(ihm_pkg::KIND_GET, pool_key[4], pool_hash[0], '0, 7'd0);

      // fill the store until sets are refused
      send_idle_pct = 33;
      recv_idle_pct = 56;
      for (int i = 3; i < 70; i++)
         send_word(ihm_pkg::KIND_SET, pool_key[i], pool_hash[i], {$urandom, $urandom}, 7'd0);
      send_word(ihm_pkg::KIND_NEXT, '0, '0, '0, 7'd63);

      // hold off until every result is back
      drop_valid();
      wait (outstanding == 0);

      for (int i = 0; i < 100; i++) random_word();
      send_idle_pct = 56;
      recv_idle_pct = 33;
      for (int i = 0; i < 140; i++) random_word();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < 140; i++) random_word();
      drop_valid();

      wait (outstanding == 0);
      repeat (400) @(posedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/ihm_pkg.sv
rtl/core/ihm_front.sv
rtl/core/ihm_back.sv
rtl/core/insertion_ordered_hash_map_unit.sv
tb/insertion_ordered_hash_map_checker.sv
tb/insertion_ordered_hash_map_unit_test.sv
